// ===== src/barc_pkg.sv =====
`default_nettype none

package barc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned OUT_BITS       = 20;

  // per-item flags that ride along the divider
  typedef struct packed {
    logic deg;
    logic neg_v;
    logic neg_w;
  } side_t;

endpackage

`default_nettype wire

// ===== src/barc_if.sv =====
`default_nettype none

interface barc_in_if #(
  parameter int unsigned COORD_BITS = barc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] corner_a_x;
  logic signed [COORD_BITS-1:0] corner_a_y;
  logic signed [COORD_BITS-1:0] corner_a_z;
  logic signed [COORD_BITS-1:0] corner_b_x;
  logic signed [COORD_BITS-1:0] corner_b_y;
  logic signed [COORD_BITS-1:0] corner_b_z;
  logic signed [COORD_BITS-1:0] corner_c_x;
  logic signed [COORD_BITS-1:0] corner_c_y;
  logic signed [COORD_BITS-1:0] corner_c_z;

  modport source (
    output valid, point_x, point_y, point_z, corner_a_x, corner_a_y, corner_a_z,
           corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, corner_a_x, corner_a_y, corner_a_z,
           corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
    output ready
  );
endinterface

interface barc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [barc_pkg::OUT_BITS-1:0]  weight_u;
  logic signed [barc_pkg::OUT_BITS-1:0]  weight_v;
  logic signed [barc_pkg::OUT_BITS-1:0]  weight_w;
  logic                                  degenerate;
  logic                                  saturated;

  modport source (
    output valid, weight_u, weight_v, weight_w, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, weight_u, weight_v, weight_w, degenerate, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/barc_div.sv =====
`default_nettype none

module barc_div #(
  parameter int unsigned NW = 73,
  parameter int unsigned FB = barc_pkg::FRAC_BITS_DEF,
  localparam int unsigned QB = NW + FB + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire barc_pkg::side_t   side_i,
  input  wire logic [NW-1:0]     den_i,
  input  wire logic [NW-1:0]     num_v_i,
  input  wire logic [NW-1:0]     num_w_i,
  output logic                   valid_o,
  output barc_pkg::side_t        side_o,
  output logic [QB-1:0]          quo_v_o,
  output logic [QB-1:0]          quo_w_o
);

  logic            vld_q  [QB];
  barc_pkg::side_t side_q [QB];
  logic [NW-1:0]   dv_q   [QB];
  logic [NW-1:0]   rem_q  [QB][2];
  logic [QB-1:0]   dq_q   [QB][2];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic            vld_in;
    barc_pkg::side_t side_in;
    logic [NW-1:0]   dv_in;
    logic [NW-1:0]   rem_in [2];
    logic [QB-1:0]   dq_in  [2];
    logic [NW-1:0]   rem_d  [2];
    logic [QB-1:0]   dq_d   [2];

    if (i == 0) begin : g_first
      assign vld_in    = valid_i;
      assign side_in   = side_i;
      assign dv_in     = den_i;
      assign rem_in[0] = '0;
      assign rem_in[1] = '0;
      assign dq_in[0]  = {num_v_i, {(FB+1){1'b0}}};
      assign dq_in[1]  = {num_w_i, {(FB+1){1'b0}}};
    end else begin : g_next
      assign vld_in    = vld_q[i-1];
      assign side_in   = side_q[i-1];
      assign dv_in     = dv_q[i-1];
      assign rem_in[0] = rem_q[i-1][0];
      assign rem_in[1] = rem_q[i-1][1];
      assign dq_in[0]  = dq_q[i-1][0];
      assign dq_in[1]  = dq_q[i-1][1];
    end

    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [NW:0] trial;
      logic        ge;
      assign trial    = {rem_in[k], dq_in[k][QB-1]};
      assign ge       = trial >= {1'b0, dv_in};
      assign rem_d[k] = ge ? NW'(trial - {1'b0, dv_in}) : trial[NW-1:0];
      assign dq_d[k]  = {dq_in[k][QB-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i]   <= side_in;
        dv_q[i]     <= dv_in;
        rem_q[i][0] <= rem_d[0];
        rem_q[i][1] <= rem_d[1];
        dq_q[i][0]  <= dq_d[0];
        dq_q[i][1]  <= dq_d[1];
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign side_o  = side_q[QB-1];
  assign quo_v_o = dq_q[QB-1][0];
  assign quo_w_o = dq_q[QB-1][1];

endmodule

`default_nettype wire

// ===== src/barycentric_coordinates_unit.sv =====
// throughput: one item per cycle; the whole pipeline advances whenever the output is free
// depth is set by the restoring divider, one quotient bit per stage, 4*CB+FB+10 stages
// reset: asynchronous active low, clears all valid bits; payload registers are not reset
`default_nettype none

module barycentric_coordinates_unit #(
  parameter int unsigned COORD_BITS = barc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = barc_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  barc_in_if.sink     req_i,
  barc_out_if.source  rsp_o
);

  localparam int unsigned OB = barc_pkg::OUT_BITS;
  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned MW = 2 * EW;
  localparam int unsigned DW = MW + 2;
  localparam int unsigned LW = (DW + 1) / 2;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned QB = NW + FRAC_BITS + 1;
  localparam int unsigned UW = QB + 3;
  localparam int unsigned PA [6] = '{0, 1, 2, 1, 0, 1};
  localparam int unsigned PB [6] = '{2, 1, 3, 4, 4, 3};
  localparam logic signed [UW-1:0] ONE = UW'(1) << FRAC_BITS;
  localparam logic [OB-1:0] MAX_W = {1'b0, {(OB-1){1'b1}}};
  localparam logic [OB-1:0] MIN_W = {1'b1, {(OB-1){1'b0}}};

  logic en;
  logic out_vld_q;
  logic [6:0] vld_q;

  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  logic signed [COORD_BITS-1:0] pt [3], ca [3], cb [3], cc [3];
  assign pt[0] = req_i.point_x;    assign pt[1] = req_i.point_y;    assign pt[2] = req_i.point_z;
  assign ca[0] = req_i.corner_a_x; assign ca[1] = req_i.corner_a_y; assign ca[2] = req_i.corner_a_z;
  assign cb[0] = req_i.corner_b_x; assign cb[1] = req_i.corner_b_y; assign cb[2] = req_i.corner_b_z;
  assign cc[0] = req_i.corner_c_x; assign cc[1] = req_i.corner_c_y; assign cc[2] = req_i.corner_c_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], req_i.valid};
    end
  end

  // edge vectors
  logic signed [EW-1:0] e_q [3][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        e_q[0][j] <= EW'(cb[j]) - EW'(ca[j]);
        e_q[1][j] <= EW'(cc[j]) - EW'(ca[j]);
        e_q[2][j] <= EW'(pt[j]) - EW'(ca[j]);
      end
    end
  end

  // component products for d00 d01 d11 d20 d21
  logic signed [MW-1:0] pr_q [5][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pr_q[0][j] <= MW'(e_q[0][j]) * MW'(e_q[0][j]);
        pr_q[1][j] <= MW'(e_q[0][j]) * MW'(e_q[1][j]);
        pr_q[2][j] <= MW'(e_q[1][j]) * MW'(e_q[1][j]);
        pr_q[3][j] <= MW'(e_q[2][j]) * MW'(e_q[0][j]);
        pr_q[4][j] <= MW'(e_q[2][j]) * MW'(e_q[1][j]);
      end
    end
  end

  logic signed [DW-1:0] dot_q [5];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < 5; n++) begin
        dot_q[n] <= DW'(pr_q[n][0]) + DW'(pr_q[n][1]) + DW'(pr_q[n][2]);
      end
    end
  end

  // wide products split into low and high partial products
  logic signed [PW-1:0] pl_q [6], ph_q [6], full_q [6];
  for (genvar m = 0; m < 6; m++) begin : g_mul
    logic [LW-1:0]           a_lo;
    logic signed [DW-LW-1:0] a_hi;
    assign a_lo = dot_q[PA[m]][LW-1:0];
    assign a_hi = dot_q[PA[m]][DW-1:LW];

    always_ff @(posedge clk_i) begin
      if (en) begin
        pl_q[m]   <= PW'($signed({1'b0, a_lo})) * PW'(dot_q[PB[m]]);
        ph_q[m]   <= PW'(a_hi) * PW'(dot_q[PB[m]]);
        full_q[m] <= (ph_q[m] <<< LW) + pl_q[m];
      end
    end
  end

  logic signed [NW-1:0] den_q, nv_q, nw_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= NW'(full_q[0]) - NW'(full_q[1]);
      nv_q  <= NW'(full_q[2]) - NW'(full_q[3]);
      nw_q  <= NW'(full_q[4]) - NW'(full_q[5]);
    end
  end

  logic [NW-1:0]   dabs_q, nvabs_q, nwabs_q;
  barc_pkg::side_t side_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dabs_q       <= den_q[NW-1] ? NW'(-den_q) : NW'(den_q);
      nvabs_q      <= nv_q[NW-1]  ? NW'(-nv_q)  : NW'(nv_q);
      nwabs_q      <= nw_q[NW-1]  ? NW'(-nw_q)  : NW'(nw_q);
      side_q.deg   <= den_q == '0;
      side_q.neg_v <= nv_q[NW-1] ^ den_q[NW-1];
      side_q.neg_w <= nw_q[NW-1] ^ den_q[NW-1];
    end
  end

  logic            dv_vld;
  barc_pkg::side_t dv_side;
  logic [QB-1:0]   quo_v, quo_w;

  barc_div #(
    .NW (NW),
    .FB (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[6]),
    .side_i  (side_q),
    .den_i   (dabs_q),
    .num_v_i (nvabs_q),
    .num_w_i (nwabs_q),
    .valid_o (dv_vld),
    .side_o  (dv_side),
    .quo_v_o (quo_v),
    .quo_w_o (quo_w)
  );

  // round half away from zero, then restore sign
  logic [QB-1:0]         rv, rw;
  logic signed [QB:0]    v_q, w_q;
  logic                  r_vld_q;
  logic                  r_deg_q;
  assign rv = QB'(({1'b0, quo_v} + (QB+1)'(1)) >> 1);
  assign rw = QB'(({1'b0, quo_w} + (QB+1)'(1)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q     <= dv_side.neg_v ? -$signed({1'b0, rv}) : $signed({1'b0, rv});
      w_q     <= dv_side.neg_w ? -$signed({1'b0, rw}) : $signed({1'b0, rw});
      r_deg_q <= dv_side.deg;
    end
  end

  // u, saturation, output register
  logic signed [UW-1:0] wt [3];
  logic [OB-1:0]        wsat [3];
  logic [2:0]           clip;
  assign wt[1] = UW'(v_q);
  assign wt[2] = UW'(w_q);
  assign wt[0] = ONE - wt[1] - wt[2];

  for (genvar k = 0; k < 3; k++) begin : g_sat
    logic [UW-OB:0] hi;
    assign hi      = wt[k][UW-1:OB-1];
    assign clip[k] = !((&hi) || !(|hi));
    assign wsat[k] = !clip[k] ? wt[k][OB-1:0] : (wt[k][UW-1] ? MIN_W : MAX_W);
  end

  logic [OB-1:0] u_q, wv_q, ww_q;
  logic          deg_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q   <= r_deg_q ? '0 : wsat[0];
      wv_q  <= r_deg_q ? '0 : wsat[1];
      ww_q  <= r_deg_q ? '0 : wsat[2];
      deg_q <= r_deg_q;
      sat_q <= !r_deg_q && (|clip);
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.weight_u   = $signed(u_q);
  assign rsp_o.weight_v   = $signed(wv_q);
  assign rsp_o.weight_w   = $signed(ww_q);
  assign rsp_o.degenerate = deg_q;
  assign rsp_o.saturated  = sat_q;

`ifndef ASSERT_OFF
  logic [OB+1:0] wsum;
  assign wsum = (OB+2)'(rsp_o.weight_u) + (OB+2)'(rsp_o.weight_v) + (OB+2)'(rsp_o.weight_w);

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.degenerate |->
      rsp_o.weight_u == '0 && rsp_o.weight_v == '0 && rsp_o.weight_w == '0 && !rsp_o.saturated)
    else $error("degenerate result with nonzero weights");

  a_sum_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.degenerate && !rsp_o.saturated |-> wsum == (OB+2)'(ONE))
    else $error("unclamped weights do not sum to one");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.saturated |->
      u_q == MAX_W || u_q == MIN_W || wv_q == MAX_W || wv_q == MIN_W ||
      ww_q == MAX_W || ww_q == MIN_W)
    else $error("saturated flag without a clamped weight");
`endif

endmodule

`default_nettype wire
